@@ sv/m3i_pkg.sv @@
`default_nettype none
package m3i_pkg;

  localparam int EW  = 32;
  localparam int PW  = 2 * EW;
  localparam int AW  = PW + 1;
  localparam int DW  = EW + AW + 2;
  localparam int ADW = DW - 1;
  localparam int QW  = EW - 1;
  localparam int WW  = ADW + QW + 1;
  localparam int LANE_LAT = QW + 2;
  localparam int NUM_EL = 9;

  typedef logic [3:0] idx_t;

  // a*b - c*d operand indexes for each adjugate element
  localparam idx_t MINOR_IDX [NUM_EL][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7},
    '{4'd2, 4'd7, 4'd1, 4'd8},
    '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8},
    '{4'd0, 4'd8, 4'd2, 4'd6},
    '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd4, 4'd6},
    '{4'd1, 4'd6, 4'd0, 4'd7},
    '{4'd0, 4'd4, 4'd1, 4'd3}
  };

  localparam logic [EW-1:0] SAT_POS = {1'b0, {(EW-1){1'b1}}};
  localparam logic [EW-1:0] SAT_NEG = {1'b1, {(EW-1){1'b0}}};

  typedef struct packed {
    logic              sing;
    logic [NUM_EL-1:0] neg;
  } m3i_side_t;

endpackage
`default_nettype wire

@@ sv/m3i_div.sv @@
`default_nettype none
module m3i_div (
  input  wire logic                     clk,
  input  wire logic [m3i_pkg::WW-1:0]   num_i,
  input  wire logic [m3i_pkg::ADW-1:0]  den_i,
  output logic      [m3i_pkg::QW-1:0]   quo_o,
  output logic                          big_o
);

  logic [m3i_pkg::WW-1:0]  num_r;
  logic [m3i_pkg::ADW-1:0] dena_r;
  logic [m3i_pkg::WW-1:0]  rem_r [0:m3i_pkg::QW];
  logic [m3i_pkg::ADW-1:0] den_r [0:m3i_pkg::QW];
  logic [m3i_pkg::QW-1:0]  quo_r [0:m3i_pkg::QW];
  logic                    big_r [0:m3i_pkg::QW];

  always_ff @(posedge clk) begin
    num_r    <= num_i;
    dena_r   <= den_i;
    rem_r[0] <= num_r;
    den_r[0] <= dena_r;
    quo_r[0] <= '0;
    big_r[0] <= num_r >= (m3i_pkg::WW'(dena_r) << m3i_pkg::QW);
  end

  for (genvar k = 0; k < m3i_pkg::QW; k++) begin : g_stage
    logic [m3i_pkg::WW-1:0] trial;
    logic                   ge;
    logic [m3i_pkg::WW-1:0] rem_nxt;
    assign trial   = m3i_pkg::WW'(den_r[k]) << (m3i_pkg::QW - 1 - k);
    assign ge      = rem_r[k] >= trial;
    assign rem_nxt = ge ? rem_r[k] - trial : rem_r[k];
    always_ff @(posedge clk) begin
      rem_r[k+1] <= rem_nxt;
      den_r[k+1] <= den_r[k];
      quo_r[k+1] <= {quo_r[k][m3i_pkg::QW-2:0], ge};
      big_r[k+1] <= big_r[k];
    end
  end

  assign quo_o = quo_r[m3i_pkg::QW];
  assign big_o = big_r[m3i_pkg::QW];

endmodule
`default_nettype wire

@@ sv/matrix3x3_inverse_top.sv @@
// 3x3 matrix inverse by adjugate over determinant, signed fixed point with FRAC_BITS
// fraction bits. One item is taken every cycle (busy stays low) and its result
// comes out on out_valid at the end of the pipeline, whose length is set by the
// restoring divider, one quotient bit per stage, 31 stages, plus product, sum and
// setup stages. The receiver cannot stall, so results must be taken as they appear.
// Matrices with |det| at or below singular_limit give out_singular and zero elements;
// others saturate to the 32-bit range. singular_limit sits at address 0 of the APB port.
`default_nettype none
module matrix3x3_inverse_top #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] in_m00,
  input  wire logic [31:0] in_m01,
  input  wire logic [31:0] in_m02,
  input  wire logic [31:0] in_m10,
  input  wire logic [31:0] in_m11,
  input  wire logic [31:0] in_m12,
  input  wire logic [31:0] in_m20,
  input  wire logic [31:0] in_m21,
  input  wire logic [31:0] in_m22,
  output logic             out_valid,
  output logic      [31:0] out_r00,
  output logic      [31:0] out_r01,
  output logic      [31:0] out_r02,
  output logic      [31:0] out_r10,
  output logic      [31:0] out_r11,
  output logic      [31:0] out_r12,
  output logic      [31:0] out_r20,
  output logic      [31:0] out_r21,
  output logic      [31:0] out_r22,
  output logic             out_singular,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int N = m3i_pkg::NUM_EL;

  logic [30:0] lim_r;

  logic signed [31:0] m_in [N];
  logic signed [31:0] m_r [N];
  logic               v1_r;
  logic signed [m3i_pkg::PW-1:0] prod_r [2*N];
  logic signed [31:0] e2_r [3];
  logic               v2_r;
  logic signed [m3i_pkg::AW-1:0] adj_r [N];
  logic signed [31:0] e3_r [3];
  logic               v3_r;
  logic signed [m3i_pkg::AW-1:0] pl_r [3];
  logic signed [m3i_pkg::AW-1:0] ph_r [3];
  logic [m3i_pkg::PW-1:0] adjabs4_r [N];
  logic [N-1:0]       adjneg4_r;
  logic               v4_r;
  logic signed [m3i_pkg::DW-1:0] det_r;
  logic [m3i_pkg::PW-1:0] adjabs5_r [N];
  logic [N-1:0]       adjneg5_r;
  logic               v5_r;
  logic [m3i_pkg::ADW-1:0] absdet_r;
  logic [m3i_pkg::PW-1:0] adjabs6_r [N];
  m3i_pkg::m3i_side_t side6_r;
  logic               v6_r;
  m3i_pkg::m3i_side_t side_r [0:m3i_pkg::LANE_LAT-1];
  logic               vl_r [0:m3i_pkg::LANE_LAT-1];
  logic [m3i_pkg::QW-1:0] quo [N];
  logic [N-1:0]       big;
  logic [31:0]        res_r [N];
  logic               out_valid_r;
  logic               out_sing_r;

  logic signed [m3i_pkg::DW-1:0] det_nxt;
  logic [m3i_pkg::ADW-1:0] absdet_nxt;

  function automatic int MINOR_A(input int i);
    return int'(m3i_pkg::MINOR_IDX[i][0]);
  endfunction
  function automatic int MINOR_B(input int i);
    return int'(m3i_pkg::MINOR_IDX[i][1]);
  endfunction
  function automatic int MINOR_C(input int i);
    return int'(m3i_pkg::MINOR_IDX[i][2]);
  endfunction
  function automatic int MINOR_D(input int i);
    return int'(m3i_pkg::MINOR_IDX[i][3]);
  endfunction

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {1'b0, lim_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= '0;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      lim_r <= pwdata[30:0];
    end
  end

  assign m_in[0] = in_m00;
  assign m_in[1] = in_m01;
  assign m_in[2] = in_m02;
  assign m_in[3] = in_m10;
  assign m_in[4] = in_m11;
  assign m_in[5] = in_m12;
  assign m_in[6] = in_m20;
  assign m_in[7] = in_m21;
  assign m_in[8] = in_m22;

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      for (int i = 0; i < m3i_pkg::LANE_LAT; i++) vl_r[i] <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      vl_r[0] <= v6_r;
      for (int i = 1; i < m3i_pkg::LANE_LAT; i++) vl_r[i] <= vl_r[i-1];
      out_valid_r <= vl_r[m3i_pkg::LANE_LAT-1];
    end
  end

  assign det_nxt = ((m3i_pkg::DW'(ph_r[0]) <<< 32) + m3i_pkg::DW'(pl_r[0]))
                 + ((m3i_pkg::DW'(ph_r[1]) <<< 32) + m3i_pkg::DW'(pl_r[1]))
                 + ((m3i_pkg::DW'(ph_r[2]) <<< 32) + m3i_pkg::DW'(pl_r[2]));

  assign absdet_nxt = det_r[m3i_pkg::DW-1] ? m3i_pkg::ADW'(-det_r)
                                           : m3i_pkg::ADW'(det_r);

  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) m_r[i] <= m_in[i];
    // element products
    for (int i = 0; i < N; i++) begin
      prod_r[2*i]   <= m_r[MINOR_A(i)] * m_r[MINOR_B(i)];
      prod_r[2*i+1] <= m_r[MINOR_C(i)] * m_r[MINOR_D(i)];
    end
    for (int j = 0; j < 3; j++) e2_r[j] <= m_r[j];
    // cofactors
    for (int i = 0; i < N; i++) begin
      adj_r[i] <= m3i_pkg::AW'(prod_r[2*i]) - m3i_pkg::AW'(prod_r[2*i+1]);
    end
    for (int j = 0; j < 3; j++) e3_r[j] <= e2_r[j];
    // determinant partial products along row 0
    pl_r[0] <= e3_r[0] * $signed({1'b0, adj_r[0][31:0]});
    ph_r[0] <= e3_r[0] * $signed(adj_r[0][m3i_pkg::AW-1:32]);
    pl_r[1] <= e3_r[1] * $signed({1'b0, adj_r[3][31:0]});
    ph_r[1] <= e3_r[1] * $signed(adj_r[3][m3i_pkg::AW-1:32]);
    pl_r[2] <= e3_r[2] * $signed({1'b0, adj_r[6][31:0]});
    ph_r[2] <= e3_r[2] * $signed(adj_r[6][m3i_pkg::AW-1:32]);
    for (int i = 0; i < N; i++) begin
      adjneg4_r[i] <= adj_r[i][m3i_pkg::AW-1];
      adjabs4_r[i] <= adj_r[i][m3i_pkg::AW-1] ? m3i_pkg::PW'(-adj_r[i])
                                              : m3i_pkg::PW'(adj_r[i]);
    end
    det_r     <= det_nxt;
    adjneg5_r <= adjneg4_r;
    for (int i = 0; i < N; i++) adjabs5_r[i] <= adjabs4_r[i];
    absdet_r     <= absdet_nxt;
    side6_r.sing <= (m3i_pkg::ADW'(lim_r) << (2 * FRAC_BITS)) >= absdet_nxt;
    side6_r.neg  <= adjneg5_r ^ {N{det_r[m3i_pkg::DW-1]}};
    for (int i = 0; i < N; i++) adjabs6_r[i] <= adjabs5_r[i];
    side_r[0] <= side6_r;
    for (int i = 1; i < m3i_pkg::LANE_LAT; i++) side_r[i] <= side_r[i-1];
    // output formatting
    out_sing_r <= side_r[m3i_pkg::LANE_LAT-1].sing;
    for (int i = 0; i < N; i++) begin
      if (side_r[m3i_pkg::LANE_LAT-1].sing) begin
        res_r[i] <= '0;
      end else if (side_r[m3i_pkg::LANE_LAT-1].neg[i]) begin
        res_r[i] <= big[i] ? m3i_pkg::SAT_NEG : 32'(-{1'b0, quo[i]});
      end else begin
        res_r[i] <= big[i] ? m3i_pkg::SAT_POS : {1'b0, quo[i]};
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_lane
    logic [m3i_pkg::WW-1:0] num;
    assign num = (m3i_pkg::WW'(adjabs6_r[i]) << (2 * FRAC_BITS))
               + m3i_pkg::WW'(absdet_r >> 1);
    m3i_div u_div (
      .clk   (clk),
      .num_i (num),
      .den_i (absdet_r),
      .quo_o (quo[i]),
      .big_o (big[i])
    );
  end

  assign out_valid    = out_valid_r;
  assign out_singular = out_sing_r;
  assign out_r00 = res_r[0];
  assign out_r01 = res_r[1];
  assign out_r02 = res_r[2];
  assign out_r10 = res_r[3];
  assign out_r11 = res_r[4];
  assign out_r12 = res_r[5];
  assign out_r20 = res_r[6];
  assign out_r21 = res_r[7];
  assign out_r22 = res_r[8];

`ifndef SYNTH
  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");
  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_singular |-> (out_r00 == 32'd0) && (out_r11 == 32'd0)
      && (out_r22 == 32'd0) && (out_r01 == 32'd0) && (out_r12 == 32'd0))
    else $error("singular item with nonzero elements");
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(v6_r, m3i_pkg::LANE_LAT + 1))
    else $error("result without matching item");
  a_zero_det: assert property (@(posedge clk) disable iff (!rst_n)
    v6_r && (absdet_r == '0) |=> side_r[0].sing)
    else $error("zero determinant not flagged");
`endif

endmodule
`default_nettype wire
